[rtl/chm_pkg.sv]
package chm_pkg;

   // Fixed field widths of the request and response transactions.
   localparam int ACT_W   = 2;
   localparam int WORD_W  = 32;
   localparam int RCH_W   = 4;
   localparam int RBIN_W  = 12;
   localparam int CHF_W   = 6;
   localparam int POS_W   = 10;

   localparam int CNT_W   = 32;
   localparam int SUM_W   = 44;
   localparam int SQ_W    = 56;
   localparam int MOM_W   = CNT_W + SUM_W + SQ_W;

   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 168;
   localparam int RSP_USER_W = 2;

   // Block word decoding.
   localparam int HEADER_BIT = 31;
   localparam int CHAN_LSB   = 22;
   localparam logic [POS_W-1:0] FIRST_DATA_POS = 10'd3;
   localparam logic [POS_W-1:0] HEADER_POS     = 10'd1;

   // Action codes carried in the request user field.
   localparam logic [ACT_W-1:0] ACT_DATA     = 2'd0;
   localparam logic [ACT_W-1:0] ACT_READ_BIN = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ_MOM = 2'd2;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_HEADER = 2'd1,
      ST_SKIPPED    = 2'd2,
      ST_CHAN_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE     = 2'd0,
      OP_UPDATE   = 2'd1,
      OP_READ_BIN = 2'd2,
      OP_READ_MOM = 2'd3
   } op_type;

   // Decoded command handed from the parser to the accumulate stage.
   typedef struct packed {
      op_type     op;
      status_type status;
      logic       bin_ok;
   } cmd_type;

endpackage

[rtl/chm_ram.sv]
module chm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // A read in the same cycle as a write to that entry returns the old data.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/chm_parse.sv]
module chm_parse #(
   parameter int CHANNELS = 16,
   parameter int BLOCK_WORD_LIMIT = 515,
   parameter int VALUE_BITS = 12,
   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
   localparam int HA_W = $clog2(CHANNELS << VALUE_BITS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [chm_pkg::ACT_W-1:0]     action,
   input  logic [chm_pkg::WORD_W-1:0]    data_word,
   input  logic                          block_start,
   input  logic [chm_pkg::RCH_W-1:0]     read_channel,
   input  logic [chm_pkg::RBIN_W-1:0]    read_bin,
   output chm_pkg::cmd_type              cmd,
   output logic [HA_W-1:0]               hist_addr,
   output logic [CH_W-1:0]               chan,
   output logic [VALUE_BITS-1:0]         value,
   output logic [2*VALUE_BITS-1:0]       square
);

   import chm_pkg::*;

   localparam logic [POS_W-1:0] LIMIT     = POS_W'(BLOCK_WORD_LIMIT);
   localparam logic [CHF_W:0]   CHAN_SPAN = (CHF_W + 1)'(CHANNELS);
   localparam logic [16:0]      BIN_SPAN  = 17'(2 ** VALUE_BITS);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             ok_ff, ok_in;
   logic [CHF_W-1:0] data_chan;
   logic [CHF_W-1:0] sel_chan;
   logic [15:0]      sel_bin;
   logic [CH_W+VALUE_BITS-1:0] full_addr;

   assign data_chan = data_word[CHAN_LSB +: CHF_W];

   // Block position tracking and classification of one transaction.
   always_comb begin
      pos_in     = pos_ff;
      ok_in      = ok_ff;
      cmd.op     = OP_NONE;
      cmd.status = ST_SKIPPED;
      cmd.bin_ok = 1'b0;
      case (action)
         ACT_DATA: begin
            if (block_start) begin
               pos_in     = HEADER_POS;
               ok_in      = data_word[HEADER_BIT];
               cmd.status = data_word[HEADER_BIT] ? ST_OK : ST_BAD_HEADER;
            end else if (ok_ff) begin
               if (pos_ff < LIMIT) begin
                  pos_in = pos_ff + POS_W'(1);
               end
               if (pos_ff < FIRST_DATA_POS) begin
                  cmd.status = ST_OK;
               end else if (pos_ff >= LIMIT) begin
                  cmd.status = ST_SKIPPED;
               end else if ({1'b0, data_chan} >= CHAN_SPAN) begin
                  cmd.status = ST_CHAN_RANGE;
               end else begin
                  cmd.op     = OP_UPDATE;
                  cmd.status = ST_OK;
               end
            end
         end
         ACT_READ_BIN: begin
            if ((CHF_W + 1)'(read_channel) >= CHAN_SPAN) begin
               cmd.status = ST_CHAN_RANGE;
            end else begin
               cmd.op     = OP_READ_BIN;
               cmd.status = ST_OK;
               cmd.bin_ok = 17'(read_bin) < BIN_SPAN;
            end
         end
         ACT_READ_MOM: begin
            if ((CHF_W + 1)'(read_channel) >= CHAN_SPAN) begin
               cmd.status = ST_CHAN_RANGE;
            end else begin
               cmd.op     = OP_READ_MOM;
               cmd.status = ST_OK;
            end
         end
         default: begin
            cmd.status = ST_SKIPPED;
         end
      endcase
   end

   // Memory addresses come from the data word for updates, else from the read fields.
   always_comb begin
      if (action == ACT_DATA) begin
         sel_chan = data_chan;
         sel_bin  = 16'(data_word[VALUE_BITS-1:0]);
      end else begin
         sel_chan = CHF_W'(read_channel);
         sel_bin  = 16'(read_bin);
      end
   end

   assign full_addr = {sel_chan[CH_W-1:0], sel_bin[VALUE_BITS-1:0]};
   assign hist_addr = full_addr[HA_W-1:0];
   assign chan      = sel_chan[CH_W-1:0];
   assign value     = data_word[VALUE_BITS-1:0];
   assign square    = value * value;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         ok_ff  <= 1'b0;
      end else if (accept) begin
         pos_ff <= pos_in;
         ok_ff  <= ok_in;
      end
   end

endmodule

[rtl/chm_accum.sv]
module chm_accum #(
   parameter int CHANNELS = 16,
   parameter int VALUE_BITS = 12,
   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
   localparam int HA_W = $clog2(CHANNELS << VALUE_BITS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          advance,
   input  chm_pkg::cmd_type              cmd,
   input  logic [HA_W-1:0]               hist_addr,
   input  logic [CH_W-1:0]               chan,
   input  logic [VALUE_BITS-1:0]         value,
   input  logic [2*VALUE_BITS-1:0]       square,
   input  logic [chm_pkg::CNT_W-1:0]     hist_rdata,
   input  logic [chm_pkg::MOM_W-1:0]     mom_rdata,
   output logic                          busy,
   output logic                          hist_we,
   output logic [HA_W-1:0]               hist_waddr,
   output logic [chm_pkg::CNT_W-1:0]     hist_wdata,
   output logic                          mom_we,
   output logic [CH_W-1:0]               mom_waddr,
   output logic [chm_pkg::MOM_W-1:0]     mom_wdata,
   output chm_pkg::status_type           rsp_status,
   output logic [chm_pkg::CNT_W-1:0]     rsp_bin,
   output logic [chm_pkg::CNT_W-1:0]     rsp_hits,
   output logic [chm_pkg::SUM_W-1:0]     rsp_sum,
   output logic [chm_pkg::SQ_W-1:0]      rsp_sq
);

   import chm_pkg::*;

   logic                    s1_valid_ff, s1_valid_in;
   cmd_type                 s1_cmd_ff;
   logic [HA_W-1:0]         s1_haddr_ff;
   logic [CH_W-1:0]         s1_chan_ff;
   logic [VALUE_BITS-1:0]   s1_value_ff;
   logic [2*VALUE_BITS-1:0] s1_square_ff;

   logic                    byp_h_valid_ff;
   logic [HA_W-1:0]         byp_h_addr_ff;
   logic [CNT_W-1:0]        byp_h_data_ff;
   logic                    byp_m_valid_ff;
   logic [CH_W-1:0]         byp_m_addr_ff;
   logic [MOM_W-1:0]        byp_m_data_ff;

   logic [CNT_W-1:0] hist_cur, hist_next;
   logic [MOM_W-1:0] mom_cur;
   logic [CNT_W-1:0] hits_cur, hits_next;
   logic [SUM_W-1:0] sum_cur, sum_next;
   logic [SQ_W-1:0]  sq_cur, sq_next;
   logic [SUM_W:0]   sum_ext;
   logic [SQ_W:0]    sq_ext;
   logic             update;

   // Stage occupancy: filled on accept, drained when the result moves on.
   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff    <= cmd;
         s1_haddr_ff  <= hist_addr;
         s1_chan_ff   <= chan;
         s1_value_ff  <= value;
         s1_square_ff <= square;
      end
   end

   // The RAM read was issued while the previous write landed, so take the
   // last written entry when the addresses match.
   assign hist_cur = (byp_h_valid_ff && (byp_h_addr_ff == s1_haddr_ff)) ?
                     byp_h_data_ff : hist_rdata;
   assign mom_cur  = (byp_m_valid_ff && (byp_m_addr_ff == s1_chan_ff)) ?
                     byp_m_data_ff : mom_rdata;

   assign hits_cur = mom_cur[CNT_W-1:0];
   assign sum_cur  = mom_cur[CNT_W +: SUM_W];
   assign sq_cur   = mom_cur[CNT_W + SUM_W +: SQ_W];

   // Saturating updates of the bin and the channel moments.
   always_comb begin
      hist_next = (&hist_cur) ? hist_cur : hist_cur + CNT_W'(1);
      hits_next = (&hits_cur) ? hits_cur : hits_cur + CNT_W'(1);
      sum_ext   = {1'b0, sum_cur} + (SUM_W + 1)'(s1_value_ff);
      sq_ext    = {1'b0, sq_cur} + (SQ_W + 1)'(s1_square_ff);
      sum_next  = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
      sq_next   = sq_ext[SQ_W] ? {SQ_W{1'b1}} : sq_ext[SQ_W-1:0];
   end

   assign update     = s1_valid_ff && advance && (s1_cmd_ff.op == OP_UPDATE);
   assign hist_we    = update;
   assign hist_waddr = s1_haddr_ff;
   assign hist_wdata = hist_next;
   assign mom_we     = update;
   assign mom_waddr  = s1_chan_ff;
   assign mom_wdata  = {sq_next, sum_next, hits_next};

   // Last-write registers for forwarding.
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_h_valid_ff <= 1'b0;
         byp_m_valid_ff <= 1'b0;
      end else if (update) begin
         byp_h_valid_ff <= 1'b1;
         byp_m_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         byp_h_addr_ff <= s1_haddr_ff;
         byp_h_data_ff <= hist_next;
         byp_m_addr_ff <= s1_chan_ff;
         byp_m_data_ff <= mom_wdata;
      end
   end

   // Result fields; counts are zero unless the action reads them.
   always_comb begin
      rsp_status = s1_cmd_ff.status;
      rsp_bin    = '0;
      rsp_hits   = '0;
      rsp_sum    = '0;
      rsp_sq     = '0;
      case (s1_cmd_ff.op)
         OP_READ_BIN: begin
            if (s1_cmd_ff.bin_ok) begin
               rsp_bin = hist_cur;
            end
         end
         OP_READ_MOM: begin
            rsp_hits = hits_cur;
            rsp_sum  = sum_cur;
            rsp_sq   = sq_cur;
         end
         default: begin
            rsp_bin = '0;
         end
      endcase
   end

   assign busy = s1_valid_ff;

endmodule

[rtl/channel_histogram_moments.sv]
// Path: request -> accumulate stage register -> output register driving rsp_tvalid.
// Throughput: one transaction per cycle while the output is not stalled, set by the
// read-modify-write of the histogram and moment memories, each with one read and one
// write port and a one-entry bypass.
// Reset: synchronous; afterwards a clearing sweep over CHANNELS << VALUE_BITS entries
// (65536 by default) zeroes both memories while req_tready stays low.
module channel_histogram_moments #(
   parameter int CHANNELS = 16,
   parameter int BLOCK_WORD_LIMIT = 515,
   parameter int VALUE_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: data_word[31:0], read_channel[35:32], read_bin[47:36].
   input  logic [chm_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Fields from bit 0: action[1:0], block_start[2].
   input  logic [chm_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0: bin_count[31:0], hit_count[63:32], value_sum[107:64],
   // square_sum[163:108], zero fill [167:164].
   output logic [chm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Fields from bit 0: status[1:0].
   output logic [chm_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   import chm_pkg::*;

   localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int HIST_DEPTH = CHANNELS << VALUE_BITS;
   localparam int HA_W       = $clog2(HIST_DEPTH);

   logic                    accept;
   logic                    s1_busy;
   logic                    s1_go;
   cmd_type                 cmd;
   logic [HA_W-1:0]         hist_raddr;
   logic [CH_W-1:0]         mom_raddr;
   logic [VALUE_BITS-1:0]   value;
   logic [2*VALUE_BITS-1:0] square;

   logic [CNT_W-1:0]        hist_rdata;
   logic [MOM_W-1:0]        mom_rdata;
   logic                    acc_hist_we, acc_mom_we;
   logic [HA_W-1:0]         acc_hist_waddr;
   logic [CNT_W-1:0]        acc_hist_wdata;
   logic [CH_W-1:0]         acc_mom_waddr;
   logic [MOM_W-1:0]        acc_mom_wdata;

   logic                    hist_we, mom_we;
   logic [HA_W-1:0]         hist_waddr;
   logic [CNT_W-1:0]        hist_wdata;
   logic [CH_W-1:0]         mom_waddr;
   logic [MOM_W-1:0]        mom_wdata;

   status_type              s1_status;
   logic [CNT_W-1:0]        s1_bin, s1_hits;
   logic [SUM_W-1:0]        s1_sum;
   logic [SQ_W-1:0]         s1_sq;

   logic                    clr_active_ff, clr_active_in;
   logic [HA_W-1:0]         clr_addr_ff, clr_addr_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff;
   logic [CNT_W-1:0]        rsp_bin_ff, rsp_hits_ff;
   logic [SUM_W-1:0]        rsp_sum_ff;
   logic [SQ_W-1:0]         rsp_sq_ff;

   // Handshake: the accumulate stage moves when the output register is free
   // or being emptied; a new transaction enters when the stage is empty or moving on.
   assign s1_go      = s1_busy && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clr_active_ff && (!s1_busy || s1_go);
   assign accept     = req_tvalid && req_tready;

   chm_parse #(
      .CHANNELS         (CHANNELS),
      .BLOCK_WORD_LIMIT (BLOCK_WORD_LIMIT),
      .VALUE_BITS       (VALUE_BITS)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .action       (req_tuser[ACT_W-1:0]),
      .data_word    (req_tdata[WORD_W-1:0]),
      .block_start  (req_tuser[ACT_W]),
      .read_channel (req_tdata[WORD_W +: RCH_W]),
      .read_bin     (req_tdata[WORD_W + RCH_W +: RBIN_W]),
      .cmd          (cmd),
      .hist_addr    (hist_raddr),
      .chan         (mom_raddr),
      .value        (value),
      .square       (square)
   );

   chm_accum #(
      .CHANNELS   (CHANNELS),
      .VALUE_BITS (VALUE_BITS)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .advance    (s1_go),
      .cmd        (cmd),
      .hist_addr  (hist_raddr),
      .chan       (mom_raddr),
      .value      (value),
      .square     (square),
      .hist_rdata (hist_rdata),
      .mom_rdata  (mom_rdata),
      .busy       (s1_busy),
      .hist_we    (acc_hist_we),
      .hist_waddr (acc_hist_waddr),
      .hist_wdata (acc_hist_wdata),
      .mom_we     (acc_mom_we),
      .mom_waddr  (acc_mom_waddr),
      .mom_wdata  (acc_mom_wdata),
      .rsp_status (s1_status),
      .rsp_bin    (s1_bin),
      .rsp_hits   (s1_hits),
      .rsp_sum    (s1_sum),
      .rsp_sq     (s1_sq)
   );

   // Clearing sweep after reset, one histogram entry per cycle; the moment
   // memory is cleared while the sweep address is below CHANNELS.
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + HA_W'(1);
         if (clr_addr_ff == HA_W'(HIST_DEPTH - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   // Write port selection between the sweep and the accumulate stage.
   always_comb begin
      if (clr_active_ff) begin
         hist_we    = 1'b1;
         hist_waddr = clr_addr_ff;
         hist_wdata = '0;
         mom_we     = clr_addr_ff < HA_W'(CHANNELS);
         mom_waddr  = clr_addr_ff[CH_W-1:0];
         mom_wdata  = '0;
      end else begin
         hist_we    = acc_hist_we;
         hist_waddr = acc_hist_waddr;
         hist_wdata = acc_hist_wdata;
         mom_we     = acc_mom_we;
         mom_waddr  = acc_mom_waddr;
         mom_wdata  = acc_mom_wdata;
      end
   end

   chm_ram #(
      .WIDTH (CNT_W),
      .DEPTH (HIST_DEPTH)
   ) u_hist_ram (
      .clock (clock),
      .we    (hist_we),
      .waddr (hist_waddr),
      .wdata (hist_wdata),
      .re    (accept),
      .raddr (hist_raddr),
      .rdata (hist_rdata)
   );

   chm_ram #(
      .WIDTH (MOM_W),
      .DEPTH (CHANNELS)
   ) u_mom_ram (
      .clock (clock),
      .we    (mom_we),
      .waddr (mom_waddr),
      .wdata (mom_wdata),
      .re    (accept),
      .raddr (mom_raddr),
      .rdata (mom_rdata)
   );

   // Output register of the response channel.
   always_comb begin
      if (s1_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_status_ff <= s1_status;
         rsp_bin_ff    <= s1_bin;
         rsp_hits_ff   <= s1_hits;
         rsp_sum_ff    <= s1_sum;
         rsp_sq_ff     <= s1_sq;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'b0, rsp_sq_ff, rsp_sum_ff, rsp_hits_ff, rsp_bin_ff};

   // No transaction enters while the memories are being cleared.
   assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !req_tready)
      else $error("request taken during the clearing sweep");

   // A held result in the accumulate stage blocks new transactions.
   assert property (@(posedge clock) disable iff (reset)
      (s1_busy && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while the accumulate stage is stalled");

   // A saturating increment never writes zero into a bin or a hit count.
   assert property (@(posedge clock) disable iff (reset)
      (acc_hist_we && !clr_active_ff) |->
         ((acc_hist_wdata != '0) && (acc_mom_wdata[CNT_W-1:0] != '0)))
      else $error("histogram or hit count update wrote zero");

endmodule
